### rtl/midi_track_event_parser_assert.svh
// assertion macros shared by the parser checker
`ifndef MIDI_TRACK_EVENT_PARSER_ASSERT_SVH
`define MIDI_TRACK_EVENT_PARSER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define MTEP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define MTEP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mtep_pkg.sv
// types and constants shared by the midi track event parser
package mtep_pkg;

  typedef enum logic [3:0] {
    PH_DELTA,
    PH_STATUS,
    PH_DATA1,
    PH_DATA2,
    PH_META_TYPE,
    PH_META_LEN,
    PH_META_DATA,
    PH_SYSEX_LEN,
    PH_SYSEX_DATA
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PARSE,
    ST_TABLE,
    ST_END,
    ST_SUM
  } ctrl_state_e;

  typedef enum logic [1:0] {
    T_IDLE,
    T_SEARCH,
    T_SHIFT
  } tbl_state_e;

  localparam logic [2:0] KIND_NOTE    = 3'd0;
  localparam logic [2:0] KIND_TEMPO   = 3'd1;
  localparam logic [2:0] KIND_TIMESIG = 3'd2;
  localparam logic [2:0] KIND_SUMMARY = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  localparam logic [23:0] ERR_VLQ_LONG  = 24'd1;
  localparam logic [23:0] ERR_NO_RS     = 24'd2;
  localparam logic [23:0] ERR_ILLEGAL   = 24'd3;
  localparam logic [23:0] ERR_TRUNC     = 24'd4;
  localparam logic [23:0] ERR_TBL_FULL  = 24'd5;

  localparam logic [7:0] META_STATUS   = 8'hFF;
  localparam logic [7:0] META_EOT      = 8'h2F;
  localparam logic [7:0] META_TEMPO    = 8'h51;
  localparam logic [7:0] META_TIMESIG  = 8'h58;
  localparam logic [7:0] SYSEX_START   = 8'hF0;
  localparam logic [7:0] SYSEX_ESC     = 8'hF7;
  localparam logic [7:0] CHAN_MAX      = 8'hEF;
  localparam logic [3:0] HI_NOTE_ON    = 4'h9;
  localparam logic [3:0] HI_NOTE_OFF   = 4'h8;
  localparam logic [3:0] HI_PROG       = 4'hC;
  localparam logic [3:0] HI_PRESSURE   = 4'hD;

  typedef struct packed {
    logic [3:0]  ch;
    logic [6:0]  pitch;
    logic [6:0]  vel;
    logic [30:0] tick;
  } pend_entry_t;

  typedef struct packed {
    logic        clear;
    logic        ins;
    logic        srch;
    pend_entry_t ent;
  } tbl_cmd_t;

  typedef struct packed {
    logic        done;
    logic        found;
    pend_entry_t ent;
  } tbl_rsp_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] track_id;
    logic [3:0]  channel;
    logic [6:0]  pitch;
    logic [6:0]  velocity;
    logic [30:0] start_tick;
    logic [30:0] end_tick;
    logic [23:0] value_a;
    logic [15:0] value_b;
    logic        last;
  } result_t;

endpackage

### rtl/mtep_pend_table.sv
// pending note table with serial search and shift-down removal
module mtep_pend_table import mtep_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tbl_cmd_t                       cmd_i,
  output tbl_rsp_t                       rsp_o,
  output logic [$clog2(DEPTH + 1) - 1:0] count_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  pend_entry_t mem [DEPTH];
  pend_entry_t rdata_q;
  pend_entry_t hit_q, hit_d;
  pend_entry_t key_q, key_d;
  pend_entry_t wdata;
  tbl_state_e  tst_q, tst_d;
  logic [CW-1:0] count_q, count_d, idx_q, idx_d, idx_p1, idx_p2;
  logic [AW-1:0] raddr, waddr;
  logic          we;

  assign idx_p1 = idx_q + 1'b1;
  assign idx_p2 = idx_q + CW'(2);

  always_comb begin
    tst_d   = tst_q;
    count_d = count_q;
    idx_d   = idx_q;
    hit_d   = hit_q;
    key_d   = key_q;
    raddr   = '0;
    waddr   = '0;
    wdata   = cmd_i.ent;
    we      = 1'b0;
    rsp_o   = '0;
    rsp_o.ent = hit_q;
    case (tst_q)
      T_IDLE: begin
        if (cmd_i.clear) begin
          count_d = '0;
        end
        if (cmd_i.ins) begin
          we      = 1'b1;
          waddr   = cmd_i.clear ? '0 : count_q[AW-1:0];
          count_d = cmd_i.clear ? CW'(1) : count_q + 1'b1;
        end
        if (cmd_i.srch) begin
          key_d = cmd_i.ent;
          idx_d = '0;
          tst_d = T_SEARCH;
        end
      end
      T_SEARCH: begin
        if (idx_q >= count_q) begin
          rsp_o.done = 1'b1;
          tst_d      = T_IDLE;
        end else if (rdata_q.ch == key_q.ch && rdata_q.pitch == key_q.pitch) begin
          hit_d = rdata_q;
          raddr = idx_p1[AW-1:0];
          tst_d = T_SHIFT;
        end else begin
          idx_d = idx_p1;
          raddr = idx_p1[AW-1:0];
        end
      end
      T_SHIFT: begin
        // rdata holds entry idx+1, move it down one place
        if (idx_p1 < count_q) begin
          we    = 1'b1;
          waddr = idx_q[AW-1:0];
          wdata = rdata_q;
          raddr = idx_p2[AW-1:0];
          idx_d = idx_p1;
        end else begin
          count_d     = count_q - 1'b1;
          rsp_o.done  = 1'b1;
          rsp_o.found = 1'b1;
          tst_d       = T_IDLE;
        end
      end
      default: begin
        tst_d = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tst_q   <= T_IDLE;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      tst_q   <= tst_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
    key_q <= key_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  assign count_o = count_q;

endmodule

### rtl/mtep_out_fifo.sv
// four-entry result queue in front of the output stream
module mtep_out_fifo import mtep_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  result_t    push_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output result_t    out_data_o,
  output logic [2:0] count_o
);

  result_t    buf_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] count_q;
  logic       pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != 3'd0);
  assign out_data_o  = buf_q[rd_ptr_q];
  assign count_o     = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + {2'b0, push_i} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/midi_track_event_parser.sv
// one track byte per input transaction; parsed in ST_PARSE, plus a table walk for note-offs
// most bytes need only ST_PARSE; a note-off also walks the pending table in ST_TABLE (one
//   read port of the pending table, one compare per cycle, then one shift per cycle)
// chunk end: ST_END checks truncation, ST_SUM pushes the summary; next byte taken after that
// next byte taken only once idle with at most two results waiting; results queued four deep
// reset: asynchronous active low, clears all track state; table contents need no clearing
module midi_track_event_parser import mtep_pkg::*; #(
  parameter int PENDING_DEPTH = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_data_i,      // smpte_timebase
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,    // data_byte[7:0], track_index[23:8]
  input  logic         s_axis_tuser,    // chunk_start
  input  logic         s_axis_tlast,    // chunk_end
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,    // track_id, channel, pitch, velocity, start_tick,
                                        // end_tick, value_a, value_b
  output logic [2:0]   m_axis_tuser,    // kind
  output logic         m_axis_tlast     // last_of_run
);

  localparam int CW = $clog2(PENDING_DEPTH + 1);

  ctrl_state_e state_q, state_d;
  phase_e      phase_q, phase_d, e_phase;
  logic [7:0]  rs_q, rs_d, e_rs;
  logic [30:0] tick_q, tick_d, e_tick;
  logic [27:0] acc_q, acc_d, e_acc, acc_n;
  logic [1:0]  vcnt_q, vcnt_d, e_vcnt;
  logic [7:0]  meta_q, meta_d, e_meta;
  logic [27:0] skip_q, skip_d, e_skip;
  logic [23:0] pay_q, pay_d, e_pay;
  logic [15:0] unm_q, unm_d, e_unm;
  logic        ended_q, ended_d, e_ended;
  logic        smpte_q;

  logic [7:0]  byte_q;
  logic        cs_q, ce_q;
  logic [15:0] trk_q;

  logic        in_acc;
  logic        push;
  result_t     push_r, out_r;
  logic [2:0]  fifo_cnt;
  tbl_cmd_t    tbl_cmd;
  tbl_rsp_t    tbl_rsp;
  logic [CW-1:0] tbl_cnt, e_cnt;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && (fifo_cnt <= 3'd2);
  assign cfg_ready_o   = 1'b1;

  // effective state after a chunk start clear
  assign e_phase = cs_q ? PH_DELTA : phase_q;
  assign e_rs    = cs_q ? '0 : rs_q;
  assign e_tick  = cs_q ? '0 : tick_q;
  assign e_acc   = cs_q ? '0 : acc_q;
  assign e_vcnt  = cs_q ? '0 : vcnt_q;
  assign e_meta  = cs_q ? '0 : meta_q;
  assign e_skip  = cs_q ? '0 : skip_q;
  assign e_pay   = cs_q ? '0 : pay_q;
  assign e_unm   = cs_q ? '0 : unm_q;
  assign e_ended = cs_q ? 1'b0 : ended_q;
  assign e_cnt   = cs_q ? '0 : tbl_cnt;
  assign acc_n   = {e_acc[20:0], byte_q[6:0]};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_PARSE;
        end
      end
      ST_PARSE: begin
        if (tbl_cmd.srch) begin
          state_d = ST_TABLE;
        end else if (ce_q) begin
          state_d = ST_END;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_TABLE: begin
        if (tbl_rsp.done) begin
          state_d = ce_q ? ST_END : ST_IDLE;
        end
      end
      ST_END: begin
        state_d = ST_SUM;
      end
      ST_SUM: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // datapath and results
  always_comb begin
    logic        vdone, vlong, fatal, md_go, cd_go, two;
    logic [23:0] err_code, md_pay, pay_n;
    logic [27:0] md_len, skip_n;
    logic [7:0]  cd_st;
    logic [6:0]  cd_d1, cd_d2;
    logic [31:0] tsum;
    logic [3:0]  hi;

    phase_d = phase_q;
    rs_d    = rs_q;
    tick_d  = tick_q;
    acc_d   = acc_q;
    vcnt_d  = vcnt_q;
    meta_d  = meta_q;
    skip_d  = skip_q;
    pay_d   = pay_q;
    unm_d   = unm_q;
    ended_d = ended_q;
    push    = 1'b0;
    push_r  = '0;
    push_r.track_id = trk_q;
    push_r.last     = !ce_q;
    tbl_cmd = '0;
    vdone    = !byte_q[7];
    vlong    = byte_q[7] && (e_vcnt == 2'd3);
    fatal    = 1'b0;
    err_code = '0;
    md_go    = 1'b0;
    md_len   = '0;
    md_pay   = '0;
    cd_go    = 1'b0;
    cd_st    = e_rs;
    cd_d1    = '0;
    cd_d2    = '0;
    tsum     = {1'b0, e_tick} + {4'b0, acc_n};
    two      = (e_rs[7:4] != HI_PROG) && (e_rs[7:4] != HI_PRESSURE);
    pay_n    = ((e_acc - e_skip) < 28'd3) ? {e_pay[15:0], byte_q} : e_pay;
    skip_n   = e_skip - 1'b1;
    hi       = '0;

    case (state_q)
      ST_PARSE: begin
        phase_d = e_phase;
        rs_d    = e_rs;
        tick_d  = e_tick;
        acc_d   = e_acc;
        vcnt_d  = e_vcnt;
        meta_d  = e_meta;
        skip_d  = e_skip;
        pay_d   = e_pay;
        unm_d   = e_unm;
        ended_d = e_ended;
        tbl_cmd.clear = cs_q;
        if (!e_ended) begin
          case (e_phase)
            PH_DELTA, PH_META_LEN, PH_SYSEX_LEN: begin
              acc_d  = acc_n;
              vcnt_d = vdone ? 2'd0 : e_vcnt + 1'b1;
              if (vlong) begin
                fatal    = 1'b1;
                err_code = ERR_VLQ_LONG;
              end else if (vdone) begin
                if (e_phase == PH_DELTA) begin
                  tick_d  = tsum[31] ? '1 : tsum[30:0];
                  acc_d   = '0;
                  phase_d = PH_STATUS;
                end else if (e_phase == PH_META_LEN) begin
                  skip_d = acc_n;
                  pay_d  = '0;
                  if (acc_n == '0) begin
                    md_go = 1'b1;
                  end else begin
                    phase_d = PH_META_DATA;
                  end
                end else begin
                  skip_d  = acc_n;
                  acc_d   = '0;
                  phase_d = (acc_n == '0) ? PH_DELTA : PH_SYSEX_DATA;
                end
              end
            end
            PH_STATUS: begin
              if (!byte_q[7]) begin
                if (e_rs == '0) begin
                  fatal    = 1'b1;
                  err_code = ERR_NO_RS;
                end else if (two) begin
                  pay_d   = {17'b0, byte_q[6:0]};
                  phase_d = PH_DATA2;
                end else begin
                  cd_go = 1'b1;
                  cd_d1 = byte_q[6:0];
                end
              end else if (byte_q == META_STATUS) begin
                rs_d    = '0;
                phase_d = PH_META_TYPE;
              end else if (byte_q == SYSEX_START || byte_q == SYSEX_ESC) begin
                rs_d    = '0;
                acc_d   = '0;
                phase_d = PH_SYSEX_LEN;
              end else if (byte_q <= CHAN_MAX) begin
                rs_d    = byte_q;
                phase_d = PH_DATA1;
              end else begin
                fatal    = 1'b1;
                err_code = ERR_ILLEGAL;
              end
            end
            PH_DATA1: begin
              if (two) begin
                pay_d   = {17'b0, byte_q[6:0]};
                phase_d = PH_DATA2;
              end else begin
                cd_go = 1'b1;
                cd_d1 = byte_q[6:0];
              end
            end
            PH_DATA2: begin
              cd_go = 1'b1;
              cd_d1 = e_pay[6:0];
              cd_d2 = byte_q[6:0];
              pay_d = '0;
            end
            PH_META_TYPE: begin
              meta_d  = byte_q;
              acc_d   = '0;
              phase_d = PH_META_LEN;
            end
            PH_META_DATA: begin
              pay_d  = pay_n;
              skip_d = skip_n;
              if (skip_n == '0) begin
                md_go  = 1'b1;
                md_len = e_acc;
                md_pay = pay_n;
              end
            end
            PH_SYSEX_DATA: begin
              if (e_skip != '0) begin
                skip_d = skip_n;
                if (skip_n == '0) begin
                  phase_d = PH_DELTA;
                end
              end else begin
                phase_d = PH_DELTA;
              end
            end
            default: begin
              phase_d = PH_DELTA;
            end
          endcase
        end

        if (md_go) begin
          if (e_meta == META_EOT) begin
            ended_d = 1'b1;
          end else if (e_meta == META_TEMPO && md_len >= 28'd3 && !smpte_q) begin
            push              = 1'b1;
            push_r.kind       = KIND_TEMPO;
            push_r.start_tick = e_tick;
            push_r.value_a    = md_pay;
          end else if (e_meta == META_TIMESIG && md_len >= 28'd2 && !smpte_q) begin
            push              = 1'b1;
            push_r.kind       = KIND_TIMESIG;
            push_r.start_tick = e_tick;
            if (md_len >= 28'd3) begin
              push_r.value_a = {16'b0, md_pay[23:16]};
              push_r.value_b = {8'b0, md_pay[15:8]};
            end else begin
              push_r.value_a = {16'b0, md_pay[15:8]};
              push_r.value_b = {8'b0, md_pay[7:0]};
            end
          end
          acc_d   = '0;
          pay_d   = '0;
          phase_d = PH_DELTA;
        end

        if (cd_go) begin
          hi      = cd_st[7:4];
          phase_d = PH_DELTA;
          tbl_cmd.ent.ch    = cd_st[3:0];
          tbl_cmd.ent.pitch = cd_d1;
          tbl_cmd.ent.vel   = cd_d2;
          tbl_cmd.ent.tick  = e_tick;
          if (hi == HI_NOTE_ON && cd_d2 != '0) begin
            if (e_cnt == CW'(PENDING_DEPTH)) begin
              push           = 1'b1;
              push_r.kind    = KIND_ERROR;
              push_r.value_a = ERR_TBL_FULL;
            end else begin
              tbl_cmd.ins = 1'b1;
            end
          end else if (hi == HI_NOTE_ON || hi == HI_NOTE_OFF) begin
            tbl_cmd.srch = 1'b1;
          end
        end

        if (fatal) begin
          push           = 1'b1;
          push_r.kind    = KIND_ERROR;
          push_r.value_a = err_code;
          ended_d        = 1'b1;
          phase_d        = PH_DELTA;
          acc_d          = '0;
          vcnt_d         = '0;
        end
      end
      ST_TABLE: begin
        if (tbl_rsp.done) begin
          if (tbl_rsp.found) begin
            push              = 1'b1;
            push_r.kind       = KIND_NOTE;
            push_r.channel    = tbl_rsp.ent.ch;
            push_r.pitch      = tbl_rsp.ent.pitch;
            push_r.velocity   = tbl_rsp.ent.vel;
            push_r.start_tick = tbl_rsp.ent.tick;
            push_r.end_tick   = tick_q;
          end else if (unm_q != '1) begin
            unm_d = unm_q + 1'b1;
          end
        end
      end
      ST_END: begin
        if (!ended_q && (phase_q != PH_DELTA || vcnt_q != '0)) begin
          push           = 1'b1;
          push_r.kind    = KIND_ERROR;
          push_r.value_a = ERR_TRUNC;
          push_r.last    = 1'b0;
        end
        ended_d = 1'b1;
        phase_d = PH_DELTA;
        acc_d   = '0;
        vcnt_d  = '0;
      end
      ST_SUM: begin
        push           = 1'b1;
        push_r.kind    = KIND_SUMMARY;
        push_r.value_a = 24'(tbl_cnt);
        push_r.value_b = unm_q;
        push_r.last    = 1'b1;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_DELTA;
      rs_q    <= '0;
      tick_q  <= '0;
      acc_q   <= '0;
      vcnt_q  <= '0;
      meta_q  <= '0;
      skip_q  <= '0;
      pay_q   <= '0;
      unm_q   <= '0;
      ended_q <= 1'b0;
      smpte_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      rs_q    <= rs_d;
      tick_q  <= tick_d;
      acc_q   <= acc_d;
      vcnt_q  <= vcnt_d;
      meta_q  <= meta_d;
      skip_q  <= skip_d;
      pay_q   <= pay_d;
      unm_q   <= unm_d;
      ended_q <= ended_d;
      if (cfg_valid_i) begin
        smpte_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q <= s_axis_tdata[7:0];
      trk_q  <= s_axis_tdata[23:8];
      cs_q   <= s_axis_tuser;
      ce_q   <= s_axis_tlast;
    end
  end

  mtep_pend_table #(
    .DEPTH (PENDING_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (tbl_cmd),
    .rsp_o   (tbl_rsp),
    .count_o (tbl_cnt)
  );

  mtep_out_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_r),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_r),
    .count_o     (fifo_cnt)
  );

  assign m_axis_tdata = {out_r.value_b, out_r.value_a, out_r.end_tick, out_r.start_tick,
                         out_r.velocity, out_r.pitch, out_r.channel, out_r.track_id};
  assign m_axis_tuser = out_r.kind;
  assign m_axis_tlast = out_r.last;

endmodule

### rtl/mtep_checker.sv
// port-level checks on the parser, bound to the top level
`include "midi_track_event_parser_assert.svh"

module mtep_checker import mtep_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata,
  input logic [2:0]   m_axis_tuser,
  input logic         m_axis_tlast
);

  logic out_stall, in_take, out_summary, out_trunc;

  assign out_stall   = m_axis_tvalid && !m_axis_tready;
  assign in_take     = s_axis_tvalid && s_axis_tready;
  assign out_summary = m_axis_tvalid && (m_axis_tuser == KIND_SUMMARY);
  assign out_trunc   = m_axis_tvalid && (m_axis_tuser == KIND_ERROR) &&
                       (m_axis_tdata[119:96] == ERR_TRUNC);

  `MTEP_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid, "result dropped while stalled")

  `MTEP_ASSERT_NEXT(a_busy_after_accept, in_take, !s_axis_tready, "byte taken while busy")

  `MTEP_ASSERT_SAME(a_summary_last, out_summary, m_axis_tlast, "summary not last of run")

  `MTEP_ASSERT_SAME(a_trunc_not_last, out_trunc, !m_axis_tlast, "truncation without summary")

endmodule

bind midi_track_event_parser mtep_checker u_checker (.*);

### bench/midi_track_event_parser_tb.sv
// self-checking testbench for the midi track event parser
`timescale 1ns / 1ps

module midi_track_event_parser_tb;
  import mtep_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int STALL_LIMIT = 6000;
  localparam int DRAIN_WAIT  = 80;
  localparam int RANDOM_ITEMS = 1850;
  localparam logic [30:0] TICK_CEIL = 31'h7FFF_FFFF;

  // predicts the parser's output events and holds the ones still due
  class midi_scoreboard;
    bit           smpte;
    phase_e       phase;
    logic [7:0]   run_status;
    logic [30:0]  tick;
    logic [27:0]  acc;
    int           vlq_len;
    logic [7:0]   meta_type;
    logic [27:0]  skip_left;
    logic [23:0]  payload;
    pend_entry_t  pending[$];
    logic [15:0]  unmatched;
    bit           ended;
    logic [15:0]  cur_track;
    result_t      step_q[$];
    result_t      due[$];
    int           mismatches;
    int           checked;
    int           kind_seen[5];

    function new();
      smpte = 0;
      mismatches = 0;
      checked = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
      clear_track();
    endfunction

    function void clear_track();
      phase = PH_DELTA;
      run_status = 0;
      tick = 0;
      acc = 0;
      vlq_len = 0;
      meta_type = 0;
      skip_left = 0;
      payload = 0;
      pending.delete();
      unmatched = 0;
      ended = 0;
    endfunction

    function void emit(logic [2:0] kind, logic [3:0] ch, logic [6:0] pitch, logic [6:0] vel,
                       logic [30:0] st, logic [30:0] et, logic [23:0] va, logic [15:0] vb);
      result_t r;
      r.kind = kind;
      r.track_id = cur_track;
      r.channel = ch;
      r.pitch = pitch;
      r.velocity = vel;
      r.start_tick = st;
      r.end_tick = et;
      r.value_a = va;
      r.value_b = vb;
      r.last = 1'b0;
      step_q.insert(step_q.size(), r);
    endfunction

    function void stop_with(logic [23:0] code);
      emit(KIND_ERROR, 0, 0, 0, 0, 0, code, 0);
      ended = 1;
      phase = PH_DELTA;
      acc = 0;
      vlq_len = 0;
    endfunction

    // 0 more bytes, 1 complete, 2 too long
    function int vlq_feed(logic [7:0] b);
      acc = {acc[20:0], b[6:0]};
      if (!b[7]) begin
        vlq_len = 0;
        return 1;
      end
      vlq_len++;
      if (vlq_len >= 4) begin
        vlq_len = 0;
        return 2;
      end
      return 0;
    endfunction

    function bit two_data(logic [7:0] st);
      return st[7:4] != HI_PROG && st[7:4] != HI_PRESSURE;
    endfunction

    function void channel_done(logic [7:0] st, logic [6:0] d1, logic [6:0] d2);
      pend_entry_t e;
      phase = PH_DELTA;
      if (st[7:4] == HI_NOTE_ON && d2 != 0) begin
        if (pending.size() >= TABLE_DEPTH) begin
          emit(KIND_ERROR, 0, 0, 0, 0, 0, ERR_TBL_FULL, 0);
          return;
        end
        e.ch = st[3:0];
        e.pitch = d1;
        e.vel = d2;
        e.tick = tick;
        pending.insert(pending.size(), e);
        return;
      end
      if (st[7:4] != HI_NOTE_ON && st[7:4] != HI_NOTE_OFF) return;
      foreach (pending[i]) begin
        if (pending[i].ch == st[3:0] && pending[i].pitch == d1) begin
          e = pending[i];
          pending.delete(i);
          emit(KIND_NOTE, e.ch, e.pitch, e.vel, e.tick, tick, 0, 0);
          return;
        end
      end
      if (unmatched != 16'hFFFF) unmatched++;
    endfunction

    function void meta_done();
      logic [27:0] len;
      int n;
      len = acc;
      n = (len < 3) ? int'(len) : 3;
      if (meta_type == META_EOT) begin
        ended = 1;
      end else if (meta_type == META_TEMPO && len >= 3 && !smpte) begin
        emit(KIND_TEMPO, 0, 0, 0, tick, 0, payload, 0);
      end else if (meta_type == META_TIMESIG && len >= 2 && !smpte) begin
        emit(KIND_TIMESIG, 0, 0, 0, tick, 0, (payload >> (8 * (n - 1))) & 24'hFF,
             16'((payload >> (8 * (n - 2))) & 24'hFF));
      end
      acc = 0;
      payload = 0;
      phase = PH_DELTA;
    endfunction

    function void parse(logic [7:0] b);
      int r;
      logic [31:0] sum;
      case (phase)
        PH_DELTA: begin
          r = vlq_feed(b);
          if (r == 2) stop_with(ERR_VLQ_LONG);
          else if (r == 1) begin
            sum = {1'b0, tick} + {4'b0, acc};
            tick = (sum > {1'b0, TICK_CEIL}) ? TICK_CEIL : sum[30:0];
            acc = 0;
            phase = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (b < 8'h80) begin
            if (run_status == 0) stop_with(ERR_NO_RS);
            else if (two_data(run_status)) begin
              payload = {17'b0, b[6:0]};
              phase = PH_DATA2;
            end else channel_done(run_status, b[6:0], 0);
          end else if (b == META_STATUS) begin
            run_status = 0;
            phase = PH_META_TYPE;
          end else if (b == SYSEX_START || b == SYSEX_ESC) begin
            run_status = 0;
            acc = 0;
            phase = PH_SYSEX_LEN;
          end else if (b <= CHAN_MAX) begin
            run_status = b;
            phase = PH_DATA1;
          end else stop_with(ERR_ILLEGAL);
        end
        PH_DATA1: begin
          if (two_data(run_status)) begin
            payload = {17'b0, b[6:0]};
            phase = PH_DATA2;
          end else channel_done(run_status, b[6:0], 0);
        end
        PH_DATA2: begin
          channel_done(run_status, payload[6:0], b[6:0]);
          payload = 0;
        end
        PH_META_TYPE: begin
          meta_type = b;
          acc = 0;
          phase = PH_META_LEN;
        end
        PH_META_LEN: begin
          r = vlq_feed(b);
          if (r == 2) stop_with(ERR_VLQ_LONG);
          else if (r == 1) begin
            skip_left = acc;
            payload = 0;
            if (skip_left == 0) meta_done();
            else phase = PH_META_DATA;
          end
        end
        PH_META_DATA: begin
          if (acc - skip_left < 3) payload = {payload[15:0], b};
          skip_left--;
          if (skip_left == 0) meta_done();
        end
        PH_SYSEX_LEN: begin
          r = vlq_feed(b);
          if (r == 2) stop_with(ERR_VLQ_LONG);
          else if (r == 1) begin
            skip_left = acc;
            acc = 0;
            phase = (skip_left == 0) ? PH_DELTA : PH_SYSEX_DATA;
          end
        end
        PH_SYSEX_DATA: begin
          if (skip_left > 0) skip_left--;
          if (skip_left == 0) phase = PH_DELTA;
        end
        default: phase = PH_DELTA;
      endcase
    endfunction

    function void note_input(logic [7:0] b, bit first, bit last, logic [15:0] trk);
      step_q.delete();
      cur_track = trk;
      if (first) clear_track();
      if (!ended) parse(b);
      if (last) begin
        if (!ended && (phase != PH_DELTA || vlq_len != 0)) stop_with(ERR_TRUNC);
        emit(KIND_SUMMARY, 0, 0, 0, 0, 0, 24'(pending.size()), unmatched);
        ended = 1;
        phase = PH_DELTA;
        acc = 0;
        vlq_len = 0;
      end
      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
      foreach (step_q[i]) due.insert(due.size(), step_q[i]);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatches++;
    endtask

    task check(result_t got);
      result_t e;
      if (due.size() == 0) begin
        report("unexpected event kind", got.kind, 0);
        return;
      end
      e = due.pop_front();
      checked++;
      if (e.kind < 5) kind_seen[e.kind]++;
      if (got.kind !== e.kind) report("kind", got.kind, e.kind);
      if (got.track_id !== e.track_id) report("track_id", got.track_id, e.track_id);
      if (got.channel !== e.channel) report("channel", got.channel, e.channel);
      if (got.pitch !== e.pitch) report("pitch", got.pitch, e.pitch);
      if (got.velocity !== e.velocity) report("velocity", got.velocity, e.velocity);
      if (got.start_tick !== e.start_tick) report("start_tick", got.start_tick, e.start_tick);
      if (got.end_tick !== e.end_tick) report("end_tick", got.end_tick, e.end_tick);
      if (got.value_a !== e.value_a) report("value_a", got.value_a, e.value_a);
      if (got.value_b !== e.value_b) report("value_b", got.value_b, e.value_b);
      if (got.last !== e.last) report("last_of_run", got.last, e.last);
    endtask
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic         cfg_data_i = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [23:0]  s_axis_tdata = '0;   // data_byte, track_index
  logic         s_axis_tuser = 1'b0; // chunk_start
  logic         s_axis_tlast = 1'b0; // chunk_end
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;        // track_id, channel, pitch, velocity, start_tick,
                                     // end_tick, value_a, value_b
  logic [2:0]   m_axis_tuser;        // kind
  logic         m_axis_tlast;        // last_of_run

  midi_track_event_parser dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always #5 clk_i = ~clk_i;

  midi_scoreboard sb = new();
  logic [7:0] chunk_bytes[$];
  bit  quiet = 0;
  int  items_sent = 0;
  int  chunks_sent = 0;
  int  ready_hold = 0;
  int  stall_cycles = 0;

  // output side back-pressure
  always @(posedge clk_i) begin
    if (quiet) m_axis_tready <= 1'b1;
    else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      ready_hold <= $urandom_range(0, 13);
      m_axis_tready <= 1'b0;
    end else m_axis_tready <= 1'b1;
  end

  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind = m_axis_tuser;
      got.track_id = m_axis_tdata[15:0];
      got.channel = m_axis_tdata[19:16];
      got.pitch = m_axis_tdata[26:20];
      got.velocity = m_axis_tdata[33:27];
      got.start_tick = m_axis_tdata[64:34];
      got.end_tick = m_axis_tdata[95:65];
      got.value_a = m_axis_tdata[119:96];
      got.value_b = m_axis_tdata[135:120];
      got.last = m_axis_tlast;
      sb.check(got);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles", stall_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_item(logic [7:0] b, bit first, bit last, logic [15:0] trk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {trk, b};
    s_axis_tuser <= first;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(b, first, last, trk);
    items_sent++;
  endtask

  // optionally cut short to end the chunk inside an event
  task automatic send_chunk(logic [15:0] trk, bit cut);
    int n;
    n = chunk_bytes.size();
    if (cut && n > 1) n = $urandom_range(1, n - 1);
    for (int i = 0; i < n; i++) send_item(chunk_bytes[i], i == 0, i == n - 1, trk);
    chunk_bytes.delete();
    chunks_sent++;
  endtask

  task automatic write_timebase(bit v);
    s_axis_tvalid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.smpte = v;
  endtask

  task automatic put(logic [7:0] b);
    chunk_bytes.insert(chunk_bytes.size(), b);
  endtask

  task automatic put_vlq(int unsigned v, int n);
    for (int i = n - 1; i >= 0; i--) put((8'(v >> (7 * i)) & 8'h7F) | ((i > 0) ? 8'h80 : 8'h00));
  endtask

  task automatic put_delta();
    int n;
    case ($urandom_range(0, 9))
      0: put_vlq(32'h00FF_FFFF, 4);
      1, 2: begin
        n = $urandom_range(1, 4);
        put_vlq($urandom & ((1 << (7 * n)) - 1), n);
      end
      default: put_vlq($urandom_range(0, 127), 1);
    endcase
  endtask

  task automatic put_meta(logic [7:0] mt, int len);
    put(META_STATUS);
    put(mt);
    put_vlq(len, ($urandom_range(0, 5) == 0) ? 2 : 1);
    repeat (len) put(8'($urandom));
  endtask

  // one event with random content; mostly well formed
  task automatic put_event(ref bit rs_ok);
    logic [3:0] ch;
    logic [6:0] pitch;
    ch = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 1));
    pitch = ($urandom_range(0, 5) == 0) ? 7'($urandom) : 7'($urandom_range(60, 63));
    put_delta();
    case ($urandom_range(0, 24))
      0, 1, 2, 3, 4, 5: begin
        put({HI_NOTE_ON, ch}); put({1'b0, pitch}); put(8'($urandom_range(1, 127))); rs_ok = 1;
      end
      6, 7, 8: begin
        put({HI_NOTE_OFF, ch}); put({1'b0, pitch}); put(8'($urandom)); rs_ok = 1;
      end
      9, 10: begin
        put({HI_NOTE_ON, ch}); put({1'b0, pitch}); put(8'h00); rs_ok = 1;
      end
      11, 12, 13: begin
        if (rs_ok) begin
          put({1'b0, pitch});
          put(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 127)));
        end else begin
          put({HI_NOTE_ON, ch}); put({1'b0, pitch}); put(8'($urandom)); rs_ok = 1;
        end
      end
      14: begin
        put({4'($urandom_range(8'hA, 8'hE)), ch}); put(8'($urandom)); put(8'($urandom));
        rs_ok = 1;
      end
      15: begin
        put({($urandom_range(0, 1) ? HI_PROG : HI_PRESSURE), ch}); put(8'($urandom));
        rs_ok = 1;
      end
      16, 17: begin put_meta(META_TEMPO, $urandom_range(1, 5)); rs_ok = 0; end
      18, 19: begin put_meta(META_TIMESIG, $urandom_range(0, 5)); rs_ok = 0; end
      20: begin put_meta(8'($urandom), $urandom_range(0, 4)); rs_ok = 0; end
      21: begin
        put($urandom_range(0, 1) ? SYSEX_START : SYSEX_ESC);
        put_vlq($urandom_range(0, 6), 1);
        repeat (chunk_bytes[chunk_bytes.size() - 1]) put(8'($urandom));
        rs_ok = 0;
      end
      22: put(8'($urandom_range(8'hF1, 8'hF6)));
      23: put_vlq(1, 5);
      default: if (!rs_ok) put(8'($urandom_range(0, 127))); else put_meta(META_EOT, 0);
    endcase
  endtask

  // count note-ons, which overflow the pending table if count > depth, then a few releases
  task automatic put_table_fill(int count);
    put(8'h00); put({HI_NOTE_ON, 4'h3}); put(8'h00); put(8'h01);
    for (int i = 1; i < count; i++) begin
      put(8'h00); put(8'(i) & 8'h7F); put(8'($urandom_range(1, 127)));
    end
    for (int i = 0; i < 4; i++) begin
      put(8'h01); put({HI_NOTE_OFF, 4'h3}); put(8'($urandom_range(0, 70))); put(8'h40);
    end
  endtask

  initial begin
    bit rs_ok;
    int n_ev;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // note, tempo, signature, short metas, other statuses, sysex, end of track
    put(8'h00); put(8'h90); put(8'h3C); put(8'h64);
    put(8'h81); put(8'h00); put(8'h80); put(8'h3C); put(8'h00);
    put(8'h00); put_meta(META_TEMPO, 3);
    put(8'h00); put_meta(META_TIMESIG, 4);
    put(8'h00); put_meta(META_TIMESIG, 2);
    put(8'h00); put_meta(META_TEMPO, 2);
    put(8'h00); put(8'h9F); put(8'h7F); put(8'h7F);
    put(8'h05); put(8'h7F); put(8'h00);
    put(8'h00); put(8'hC5); put(8'h10); put(8'h00); put(8'hD1); put(8'h20);
    put(8'h00); put(8'hA2); put(8'h01); put(8'h02);
    put(8'h00); put(8'hE0); put(8'h7F); put(8'h7F);
    put(8'h00); put(8'hF0); put(8'h02); put(8'h11); put(8'h22);
    put(8'h00); put(8'hF7); put(8'h00);
    put(8'h00); put(8'h80); put(8'h10); put(8'h00);
    put(8'h00); put(8'h90); put(8'h20); put(8'h01);
    put(8'h00); put_meta(META_EOT, 0); put(8'h55); put(8'h90);
    send_chunk(16'h0000, 0);
    send_item(8'hAA, 0, 0, 16'h0000);
    send_item(8'hBB, 0, 1, 16'h0000);
    put(8'h00);
    send_chunk(16'hFFFF, 0);

    // fatal errors, truncation, tick saturation
    put(8'h00); put(8'hF4); put(8'h00); send_chunk(16'h0001, 0);
    put(8'h00); put(8'h40); send_chunk(16'h0002, 0);
    put_vlq(1, 5); send_chunk(16'h0003, 0);
    put(8'h00); put(8'h90); put(8'h40); send_chunk(16'h0004, 0);
    put(8'h81); send_chunk(16'h0005, 0);
    repeat (9) begin put_vlq(32'h0FFF_FFFF, 4); put(8'hFF); put(8'h51); put(8'h00); end
    put(8'h00); put_meta(META_TEMPO, 3); send_chunk(16'h0006, 0);
    put_table_fill(TABLE_DEPTH + 2); send_chunk(16'h0007, 0);

    write_timebase(1);
    put(8'h00); put_meta(META_TEMPO, 3); put(8'h00); put_meta(META_TIMESIG, 4);
    put(8'h00); put(8'h90); put(8'h30); put(8'h30); put(8'h00); put(8'h30); put(8'h00);
    send_chunk(16'h8000, 0);
    write_timebase(0);

    // random chunks, smpte switched midway
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent > RANDOM_ITEMS / 2 && !sb.smpte && chunks_sent % 3 == 0) write_timebase(1);
      else if (items_sent > 3 * RANDOM_ITEMS / 4 && sb.smpte) write_timebase(0);
      quiet = (items_sent > 7 * RANDOM_ITEMS / 8);
      if ($urandom_range(0, 29) == 0) put_table_fill($urandom_range(60, 70));
      else begin
        rs_ok = 0;
        n_ev = $urandom_range(2, 12);
        repeat (n_ev) put_event(rs_ok);
      end
      if ($urandom_range(0, 3) == 0) put_meta(META_EOT, 0);
      send_chunk(16'($urandom), $urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) == 0) begin
        send_item(8'($urandom), 0, 1'($urandom_range(0, 1)), 16'($urandom));
      end
    end

    s_axis_tvalid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("%0d track bytes in %0d chunks, %0d events checked", items_sent, chunks_sent,
             sb.checked);
    $display("notes %0d, tempo %0d, signature %0d, summary %0d, error %0d",
             sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2], sb.kind_seen[3],
             sb.kind_seen[4]);
    if (sb.mismatches == 0 && sb.due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
